// File: hw/rtl/wso_pkg.sv
// Shared types and constants of the wheel speed odometer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wso_pkg;

    // Widths of result fields, timer, dividend, in/out words
    localparam int SPEED_W    = 10;
    localparam int DIR_W      = 2;
    localparam int DIST_W     = 32;
    localparam int TIMER_W    = 32;
    localparam int DIVIDEND_W = 32;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 48;

    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(999);

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_NONE     = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic [31:0] SPEED_SCALE_RESET   = 32'd432000000;
    localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd60000000;

    // One result word, speed in the lowest bits
    typedef struct packed {
        logic [DIST_W-1:0]  distance_m;
        logic [DIR_W-1:0]   direction;
        logic [SPEED_W-1:0] speed_kmh;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } state_t;

endpackage

// File: hw/rtl/wso_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on wso_pkg for the dividend width.
`timescale 1ns / 1ps

module wso_div #(
    parameter int DIV_W = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wso_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [DIV_W-1:0]             divisor,
    output logic                         done,
    output logic [wso_pkg::DIVIDEND_W-1:0] quotient
);
    import wso_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_W:0]        rem_shift;
    logic [DIV_W:0]        diff;
    logic                  fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        fits      = ~diff[DIV_W];
        rem_next  = fits ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
        quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    // Datapath shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/wheel_speed_odometer.sv
// Wheel speed odometer top level: period counter, timeout, pulse count,
// speed by serial division. Depends on wso_pkg and wso_div.
//
//   Channel  Dir  Handshake          Word
//   s_       in   s_tvalid/s_tready  [0] tick, [1] wheel_edge, [2] reverse_level
//   m_       out  m_tvalid/m_tready  [9:0] speed_kmh, [11:10] direction,
//                                    [43:12] distance_m
//   cfg_     in   cfg_wr_en          0 speed_scale, 1 timeout_ticks
//
// A word without a wheel edge, or with an edge after a zero period, completes in
// its accept cycle. A wheel edge after a nonzero period goes through accept,
// 32 steps of the one-bit-per-cycle restoring divider, and write back.
// Reset (aresetn low, synchronous) clears all counters, speed and direction.
// A finished result waits in the output register; one more result may wait in
// a skid register, and input is held off while that one is occupied.
`timescale 1ns / 1ps

module wheel_speed_odometer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] tick, [1] wheel_edge, [2] reverse_level, [7:3] zero
    input  logic [wso_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [9:0] speed_kmh, [11:10] direction, [43:12] distance_m, [47:44] zero
    output logic [wso_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [wso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_wr_data
);
    import wso_pkg::*;

    state_t               state_reg, state_next;
    logic [31:0]          scale_reg;
    logic [31:0]          tout_ticks_reg;
    logic [COUNT_WIDTH-1:0] period_reg, period_next;
    logic [TIMER_W-1:0]   timeout_reg, timeout_next;
    logic [DIST_W-1:0]    pulse_reg, pulse_next;
    logic [SPEED_W-1:0]   speed_reg, speed_next;
    logic [DIR_W-1:0]     dir_reg, dir_next;

    result_t              out_reg, pend_reg, res;
    logic                 out_valid_reg, pend_valid_reg;
    logic                 out_free;

    logic                 in_accept;
    logic                 tick, wheel_edge, reverse_level;
    logic                 item_done;
    logic                 div_start, div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [SPEED_W-1:0]   div_speed;

    assign tick          = s_tdata[0];
    assign wheel_edge    = s_tdata[1];
    assign reverse_level = s_tdata[2];

    assign s_tready  = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    // Serial divider for speed_scale / period
    wso_div #(
        .DIV_W (COUNT_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (period_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Saturate the quotient to the display range
    assign div_speed = (div_quo > DIVIDEND_W'(SPEED_MAX)) ? SPEED_MAX
                                                          : div_quo[SPEED_W-1:0];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= SPEED_SCALE_RESET;
            tout_ticks_reg <= TIMEOUT_TICKS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SPEED_SCALE:   scale_reg      <= cfg_wr_data;
                REG_TIMEOUT_TICKS: tout_ticks_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Next state: tick handling first, then the edge wins
    always_comb begin
        state_next   = state_reg;
        period_next  = period_reg;
        timeout_next = timeout_reg;
        pulse_next   = pulse_reg;
        speed_next   = speed_reg;
        dir_next     = dir_reg;
        item_done    = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (tick) begin
                        if (period_reg != '1) begin
                            period_next = period_reg + 1'b1;
                        end
                        if (timeout_reg <= TIMER_W'(1)) begin
                            timeout_next = '0;
                            speed_next   = '0;
                            dir_next     = DIR_NONE;
                        end else begin
                            timeout_next = timeout_reg - 1'b1;
                        end
                    end
                    if (wheel_edge) begin
                        period_next  = {{(COUNT_WIDTH-1){1'b0}}, tick};
                        dir_next     = reverse_level ? DIR_BACKWARD : DIR_FORWARD;
                        pulse_next   = pulse_reg + 1'b1;
                        timeout_next = tout_ticks_reg;
                        if (period_reg == '0) begin
                            speed_next = SPEED_MAX;
                            item_done  = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end else begin
                        item_done = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    speed_next = div_speed;
                    item_done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        res.speed_kmh  = speed_next;
        res.direction  = dir_next;
        res.distance_m = pulse_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            period_reg  <= '0;
            timeout_reg <= '0;
            pulse_reg   <= '0;
            speed_reg   <= '0;
            dir_reg     <= DIR_NONE;
        end else begin
            state_reg   <= state_next;
            period_reg  <= period_next;
            timeout_reg <= timeout_next;
            pulse_reg   <= pulse_next;
            speed_reg   <= speed_next;
            dir_reg     <= dir_next;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    // Output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (pend_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
        end else if (item_done) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                pend_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pend_valid_reg) begin
            if (out_free) begin
                out_reg <= pend_reg;
            end
        end else if (item_done) begin
            if (out_free) begin
                out_reg <= res;
            end else begin
                pend_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - $bits(result_t))'(0), out_reg};

endmodule

// File: hw/rtl/wso_check.sv
// Port-level checks of the wheel speed odometer, bound to the top level.
// Depends on wso_pkg for field widths and codes.
`timescale 1ns / 1ps

module wso_check (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [wso_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [wso_pkg::OUT_W-1:0] m_tdata
);
    import wso_pkg::*;

    logic [SPEED_W-1:0] out_speed;
    logic [DIR_W-1:0]   out_dir;

    assign out_speed = m_tdata[SPEED_W-1:0];
    assign out_dir   = m_tdata[SPEED_W+DIR_W-1:SPEED_W];

    // A waiting input word stays offered and unchanged
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while waiting");

    // A stalled result word stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    // Speed never exceeds the display limit
    a_speed_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_speed <= SPEED_MAX)
        else $error("speed above limit");

    // Direction code is one of the three defined ones
    a_dir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_dir == DIR_NONE || out_dir == DIR_BACKWARD ||
                      out_dir == DIR_FORWARD))
        else $error("undefined direction code");

    // No direction means the wheel is stopped
    a_stop_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_dir == DIR_NONE |-> out_speed == '0)
        else $error("nonzero speed with no direction");

endmodule

bind wheel_speed_odometer wso_check u_wso_check (.*);

// File: bench/wheel_speed_odometer_test.sv
// Self-checking bench for wheel_speed_odometer: directed and random wheel/tick words,
// with a scoreboard that predicts speed, direction and distance for every word.
// Depends on wso_pkg and the wheel_speed_odometer RTL; runs the block with a 16-bit period.
`timescale 1ns / 1ps

import wso_pkg::*;

// Tracks the odometer state and holds the results still owed by the block
class odometer_scoreboard #(int CW = 32);
    logic [31:0]        speed_scale;
    logic [31:0]        timeout_ticks;
    logic [CW-1:0]      period_count;
    logic [31:0]        timeout_left;
    logic [DIST_W-1:0]  pulse_count;
    logic [SPEED_W-1:0] speed_hold;
    logic [DIR_W-1:0]   dir_hold;
    result_t            expected[$];
    int                 words;
    int                 checked;
    int                 mismatches;
    int                 pulses;
    int                 stops;
    int                 capped;

    function new();
        speed_scale   = SPEED_SCALE_RESET;
        timeout_ticks = TIMEOUT_TICKS_RESET;
        period_count  = '0;
        timeout_left  = '0;
        pulse_count   = '0;
        speed_hold    = '0;
        dir_hold      = DIR_NONE;
        words         = 0;
        checked       = 0;
        mismatches    = 0;
        pulses        = 0;
        stops         = 0;
        capped        = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_SPEED_SCALE:   speed_scale = val;
            REG_TIMEOUT_TICKS: timeout_ticks = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected.size();
    endfunction

    // Advance the state by one accepted word and queue the result it owes
    function void note_word(logic [2:0] w);
        logic          tick;
        logic          wheel;
        logic          rev;
        logic [CW-1:0] last_period;
        logic [63:0]   quot;
        result_t       r;
        tick        = w[0];
        wheel       = w[1];
        rev         = w[2];
        last_period = period_count;
        words++;

        // tick: count the period up to its ceiling, count the timeout down
        if (tick) begin
            if (period_count != {CW{1'b1}})
                period_count = period_count + 1'b1;
            if (timeout_left <= 32'd1) begin
                if (timeout_left == 32'd1)
                    stops++;
                timeout_left = '0;
                speed_hold   = '0;
                dir_hold     = DIR_NONE;
            end else begin
                timeout_left = timeout_left - 1'b1;
            end
        end

        // wheel pulse: speed from the period before this word, then restart
        if (wheel) begin
            if (last_period == '0) begin
                speed_hold = SPEED_MAX;
            end else begin
                quot = {32'b0, speed_scale} / 64'(last_period);
                speed_hold = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
            end
            if (speed_hold == SPEED_MAX)
                capped++;
            period_count = tick ? CW'(1) : '0;
            dir_hold     = rev ? DIR_BACKWARD : DIR_FORWARD;
            pulse_count  = pulse_count + 1'b1;
            timeout_left = timeout_ticks;
            pulses++;
        end

        r.speed_kmh  = speed_hold;
        r.direction  = dir_hold;
        r.distance_m = pulse_count;
        expected.push_back(r);
    endfunction

    // Compare one result word with the oldest owed result
    function void check_result(result_t got);
        result_t want;
        checked++;
        if (expected.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word: speed %0d dir %0d dist %0d",
                     $time, got.speed_kmh, got.direction, got.distance_m);
            return;
        end
        want = expected.pop_front();
        if (got.speed_kmh !== want.speed_kmh) begin
            mismatches++;
            $display("%0t: speed_kmh expected %0d actual %0d",
                     $time, want.speed_kmh, got.speed_kmh);
        end
        if (got.direction !== want.direction) begin
            mismatches++;
            $display("%0t: direction expected %0d actual %0d",
                     $time, want.direction, got.direction);
        end
        if (got.distance_m !== want.distance_m) begin
            mismatches++;
            $display("%0t: distance_m expected %0d actual %0d",
                     $time, want.distance_m, got.distance_m);
        end
    endfunction
endclass

module wheel_speed_odometer_test;

    // Period counter width for this run
    localparam int COUNT_W = 16;

    // Input words: {reverse_level, wheel_edge, tick}
    localparam logic [2:0] W_NONE          = 3'b000;
    localparam logic [2:0] W_TICK          = 3'b001;
    localparam logic [2:0] W_PULSE         = 3'b010;
    localparam logic [2:0] W_TICK_PULSE    = 3'b011;
    localparam logic [2:0] W_TICK_REV      = 3'b101;
    localparam logic [2:0] W_PULSE_REV     = 3'b110;
    localparam logic [2:0] W_TICK_PULSE_REV = 3'b111;

    localparam int SETTLE_CYCLES = 40;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [31:0]           cfg_wr_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    odometer_scoreboard #(COUNT_W) sb;

    wheel_speed_odometer #(
        .COUNT_WIDTH(COUNT_W)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // Check each accepted result word, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(result_t'(m_tdata[$bits(result_t)-1:0]));
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic [2:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-3){1'b0}}, w};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    // Write both registers on consecutive edges
    task automatic configure(input logic [31:0] scale, input logic [31:0] limit);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_SPEED_SCALE;
        cfg_wr_data <= scale;
        @(posedge aclk);
        sb.set_reg(REG_SPEED_SCALE, scale);
        cfg_index   <= REG_TIMEOUT_TICKS;
        cfg_wr_data <= limit;
        @(posedge aclk);
        sb.set_reg(REG_TIMEOUT_TICKS, limit);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly tick runs closed by a wheel pulse, some raw noise words
    task automatic drive_random(input int count);
        int sent;
        int run;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                run = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60)
                                                  : $urandom_range(0, 10);
                for (int i = 0; i < run && sent < count; i++) begin
                    send_word({1'($urandom_range(0, 1)), 1'b0, 1'b1});
                    sent++;
                end
                if (sent < count) begin
                    send_word({1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1))});
                    sent++;
                end
            end else begin
                run = $urandom_range(1, 4);
                for (int i = 0; i < run && sent < count; i++) begin
                    send_word(3'($urandom_range(0, 7)));
                    sent++;
                end
            end
            // pause the sender near the middle of each phase until the block has drained
            if (sent >= count / 2 && sent - run <= count / 2 && sent < count)
                settle(0);
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers: expired timeout stays cleared, zero and short periods cap
        send_word(W_NONE);
        send_word(W_TICK);
        send_word(W_TICK_REV);
        send_word(W_PULSE);
        send_word(W_PULSE_REV);
        settle(SETTLE_CYCLES);

        // Short timeout: a real quotient, then expiry and repeated expiry
        configure(32'd3000, 32'd3);
        repeat (4) send_word(W_TICK);
        send_word(W_PULSE);
        repeat (4) send_word(W_TICK);
        send_word(W_TICK_PULSE_REV);
        send_word(W_TICK_PULSE);
        settle(SETTLE_CYCLES);

        // Zero scale and zero timeout
        configure(32'd0, 32'd0);
        send_word(W_PULSE);
        send_word(W_PULSE);
        send_word(W_TICK);
        settle(SETTLE_CYCLES);

        // All-ones registers
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(W_TICK);
        send_word(W_PULSE_REV);
        settle(SETTLE_CYCLES);

        // Smallest nonzero registers
        configure(32'd1, 32'd1);
        send_word(W_TICK);
        send_word(W_PULSE);
        send_word(W_TICK);
        send_word(W_TICK_PULSE);
        settle(SETTLE_CYCLES);

        // Random phases under four idling mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            configure(32'($urandom_range(300, 30000)), 32'($urandom_range(2, 40)));
            drive_random(130);
            settle(SETTLE_CYCLES);
        end

        $display("Checked %0d results for %0d words: %0d wheel pulses, %0d timeout stops,",
                 sb.checked, sb.words, sb.pulses, sb.stops);
        $display("%0d capped speeds; zero and all-ones registers, idling mixes.",
                 sb.capped);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #25_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/wso_pkg.sv
hw/rtl/wso_div.sv
hw/rtl/wheel_speed_odometer.sv
hw/rtl/wso_check.sv
bench/wheel_speed_odometer_test.sv
